[hw/rtl/iltk_pkg.sv]
// Package for the INI line tokenizer: types, character codes, section table.
`default_nettype none
package iltk_pkg;

	localparam int LINE_BYTES = 256;
	localparam int COL_W      = $clog2(LINE_BYTES);
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_BYTES - 1);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_RBR  = 8'h5D;

	localparam logic [2:0] SEC_NONE    = 3'd0;
	localparam logic [2:0] SEC_UNIT    = 3'd1;
	localparam logic [2:0] SEC_SERVICE = 3'd2;
	localparam logic [2:0] SEC_TIMER   = 3'd3;
	localparam logic [2:0] SEC_INSTALL = 3'd4;

	localparam int NAME_MAX = 7;

	localparam logic [7:0] SECT_NAMES [4][8] = '{
		'{"U", "n", "i", "t", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "e", "r", "v", "i", "c", "e", 8'h00},
		'{"T", "i", "m", "e", "r", 8'h00, 8'h00, 8'h00},
		'{"I", "n", "s", "t", "a", "l", "l", 8'h00}
	};
	localparam logic [2:0] SECT_LENS [4] = '{3'd4, 3'd7, 3'd5, 3'd7};
	localparam logic [2:0] SECT_CODE [4] = '{SEC_UNIT, SEC_SERVICE, SEC_TIMER, SEC_INSTALL};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  section_code;
		logic [31:0] line_start;
		logic [7:0]  key_offset;
		logic [7:0]  key_length;
		logic [7:0]  value_offset;
		logic [7:0]  value_length;
	} desc_t;

	// Classified byte as handed from front to back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
		logic       nl;
		logic       nul;
		logic       sptab;
		logic       blank;
		logic       cmt;
		logic       lbr;
		logic       rbr;
		logic       eq;
	} tok_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} q_stat_t;

	typedef enum logic [5:0] {
		PH_LEAD  = 6'b000001,
		PH_KEY   = 6'b000010,
		PH_VLEAD = 6'b000100,
		PH_VBODY = 6'b001000,
		PH_NAME  = 6'b010000,
		PH_SKIP  = 6'b100000
	} phase_t;

	function automatic logic [7:0] col8(input logic [COL_W-1:0] v);
		logic [COL_W+7:0] w;
		w = {8'b0, v};
		return w[7:0];
	endfunction

endpackage
`default_nettype wire

[hw/rtl/ini_line_tokenizer.sv]
// Top level of the INI line tokenizer.
`default_nettype none
// INI line tokenizer. Bytes of an INI text buffer enter on the item channel,
// one per transfer, with final_byte marking the last byte of the buffer. Each
// line that holds '=' (and is not a comment or section header) yields one
// descriptor on the desc channel when the line closes at LF or at the final
// byte: the current section code, the stream position of the line's first
// byte, and the trimmed key and value spans as offset and length within the
// line. Section headers [Unit], [Service], [Timer] and [Install] select the
// section; any other name selects none, and the section returns to none after
// each buffer. The block sustains one byte per clock while descriptors are
// taken: the front stage classifies and registers each byte, a two-entry
// queue decouples it from the back stage, and the back stage computes all
// line state for one byte combinationally and loads the descriptor
// register. A closing byte passes the front register and a queue entry
// before it loads the descriptor register. The back stage stalls only while
// a descriptor waits untaken; the front keeps filling the queue meanwhile.
// Lines keep at most their first LINE_BYTES-1 bytes and none from a NUL on;
// the stream position saturates at 2^32-1. No clearing pass follows reset.
module ini_line_tokenizer import iltk_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       desc_valid,
	input  wire logic  desc_ready,
	output desc_t      desc
);

	logic    fq_valid;
	logic    fq_ready;
	tok_t    fq_tok;
	logic    qb_valid;
	logic    qb_ready;
	tok_t    qb_tok;
	q_stat_t q_stat;

	// Classify and register each incoming byte.
	iltk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.tok_valid  (fq_valid),
		.tok_ready  (fq_ready),
		.tok        (fq_tok)
	);

	// Hold classified bytes while the back stage stalls.
	iltk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_tok   (fq_tok),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_tok    (qb_tok),
		.stat       (q_stat)
	);

	// Advance the line state and emit descriptors.
	iltk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (qb_valid),
		.tok_ready  (qb_ready),
		.tok        (qb_tok),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc)
	);

	// Queue occupancy never exceeds its depth, and full and empty are never both set.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.count <= QCNT_W'(QDEPTH)) && !(q_stat.full && q_stat.empty))
		else $error("token queue occupancy out of range");

	// A descriptor carries one of the five section codes.
	a_section_code: assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid |-> (desc.section_code <= SEC_INSTALL))
		else $error("descriptor section code out of range");

	// The back stage never takes a token the queue does not hold.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(qb_valid && qb_ready) |-> !q_stat.empty)
		else $error("token popped from empty queue");

endmodule
`default_nettype wire

[hw/rtl/iltk_front.sv]
// Front stage: classify each incoming byte and register it.
`default_nettype none
module iltk_front import iltk_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       tok_valid,
	input  wire logic  tok_ready,
	output tok_t       tok
);

	logic valid_s1;
	tok_t tok_s1;
	tok_t cls;

	always_comb begin
		cls.data_byte  = item.data_byte;
		cls.final_byte = item.final_byte;
		cls.nl         = (item.data_byte == CH_LF);
		cls.nul        = (item.data_byte == CH_NUL);
		cls.sptab      = (item.data_byte == CH_SP) || (item.data_byte == CH_TAB);
		cls.blank      = cls.sptab || (item.data_byte == CH_CR) || cls.nl;
		cls.cmt        = (item.data_byte == CH_HASH) || (item.data_byte == CH_SEMI);
		cls.lbr        = (item.data_byte == CH_LBR);
		cls.rbr        = (item.data_byte == CH_RBR);
		cls.eq         = (item.data_byte == CH_EQ);
	end

	assign item_ready = !valid_s1 || tok_ready;
	assign tok_valid  = valid_s1;
	assign tok        = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			tok_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/iltk_queue.sv]
// Short token queue between the front and back stages.
`default_nettype none
module iltk_queue import iltk_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire tok_t push_tok,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output tok_t      pop_tok,
	output q_stat_t   stat
);

	tok_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign stat.count = cnt_q;
	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign push_ready = !stat.full;
	assign pop_valid  = !stat.empty;
	assign pop_tok    = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_tok;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/iltk_back.sv]
// Back stage: line tokenizer state and the descriptor output register.
`default_nettype none
module iltk_back import iltk_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic tok_valid,
	output logic      tok_ready,
	input  wire tok_t tok,
	output logic      desc_valid,
	input  wire logic desc_ready,
	output desc_t     desc
);

	logic [2:0]       sect_q, n_sect;
	logic [31:0]      pos_q, n_pos;
	logic [31:0]      lbeg_q, n_lbeg;
	logic [COL_W-1:0] col_q, n_col;
	phase_t           phase_q, n_phase;
	logic [COL_W-1:0] kbeg_q, n_kbeg;
	logic [COL_W-1:0] klast_q, n_klast;
	logic [COL_W-1:0] vbeg_q, n_vbeg;
	logic [COL_W-1:0] vlast_q, n_vlast;
	logic [COL_W-1:0] vmark_q, n_vmark;
	logic [2:0]       nidx_q, n_nidx;
	logic [3:0]       nalive_q, n_nalive;
	logic             cut_q, n_cut;

	logic             out_valid_q;
	desc_t            out_q;
	desc_t            res;
	logic             go;
	logic             close;
	logic             emit;
	logic [COL_W-1:0] col_nx;
	logic [COL_W-1:0] klen;
	logic [COL_W-1:0] voff;
	logic [COL_W-1:0] vlen;

	assign go         = tok_valid && (!out_valid_q || desc_ready);
	assign tok_ready  = go;
	assign desc_valid = out_valid_q;
	assign desc       = out_q;
	assign col_nx     = col_q + 1'b1;

	always_comb begin
		n_sect   = sect_q;
		n_lbeg   = lbeg_q;
		n_col    = col_q;
		n_phase  = phase_q;
		n_kbeg   = kbeg_q;
		n_klast  = klast_q;
		n_vbeg   = vbeg_q;
		n_vlast  = vlast_q;
		n_vmark  = vmark_q;
		n_nidx   = nidx_q;
		n_nalive = nalive_q;
		n_cut    = cut_q;

		// Take the byte into the line unless it is LF or the line was cut.
		if (!tok.nl && !cut_q) begin
			if (tok.nul || col_q >= COL_MAX) begin
				n_cut = 1'b1;
			end else begin
				n_col = col_nx;
				case (phase_q)
					PH_LEAD: begin
						if (!tok.sptab) begin
							n_kbeg = col_q;
							if (tok.cmt) begin
								n_phase = PH_SKIP;
							end else if (tok.lbr) begin
								n_phase  = PH_NAME;
								n_nidx   = '0;
								n_nalive = 4'hF;
							end else if (tok.eq) begin
								n_phase = PH_VLEAD;
								n_vmark = col_nx;
								n_vbeg  = col_nx;
							end else begin
								n_phase = PH_KEY;
								if (!tok.blank) n_klast = col_nx;
							end
						end
					end
					PH_KEY: begin
						if (tok.eq) begin
							n_phase = PH_VLEAD;
							n_vmark = col_nx;
							n_vbeg  = col_nx;
						end else if (!tok.blank) begin
							n_klast = col_nx;
						end
					end
					PH_VLEAD: begin
						if (!tok.sptab) begin
							n_vbeg  = col_q;
							n_phase = PH_VBODY;
							if (!tok.blank) n_vlast = col_nx;
						end
					end
					PH_VBODY: begin
						if (!tok.blank) n_vlast = col_nx;
					end
					PH_NAME: begin
						if (tok.rbr) begin
							n_sect = SEC_NONE;
							for (int k = 0; k < 4; k++) begin
								if (nalive_q[k] && SECT_LENS[k] == nidx_q) n_sect = SECT_CODE[k];
							end
							n_phase = PH_SKIP;
						end else if (nidx_q < 3'(NAME_MAX)) begin
							for (int k = 0; k < 4; k++) begin
								if (SECT_NAMES[k][nidx_q] != tok.data_byte) n_nalive[k] = 1'b0;
							end
							n_nidx = nidx_q + 1'b1;
						end else begin
							n_nalive = '0;
						end
					end
					default: begin
					end
				endcase
			end
		end

		n_pos = (pos_q != 32'hFFFF_FFFF) ? pos_q + 1'b1 : pos_q;
		close = tok.nl || tok.final_byte;
		emit  = close && (n_phase == PH_VLEAD || n_phase == PH_VBODY);

		klen = (n_klast != '0) ? n_klast - n_kbeg : '0;
		voff = (n_vlast != '0) ? n_vbeg : n_vmark;
		vlen = (n_vlast != '0) ? n_vlast - n_vbeg : '0;

		res.section_code = n_sect;
		res.line_start   = lbeg_q;
		res.key_offset   = col8(n_kbeg);
		res.key_length   = col8(klen);
		res.value_offset = col8(voff);
		res.value_length = col8(vlen);

		// Close the line: clear per-line state and mark where the next begins.
		if (close) begin
			n_col    = '0;
			n_phase  = PH_LEAD;
			n_kbeg   = '0;
			n_klast  = '0;
			n_vbeg   = '0;
			n_vlast  = '0;
			n_vmark  = '0;
			n_nidx   = '0;
			n_nalive = 4'hF;
			n_cut    = 1'b0;
			n_lbeg   = n_pos;
		end
		if (tok.final_byte) n_sect = SEC_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sect_q      <= SEC_NONE;
			pos_q       <= '0;
			lbeg_q      <= '0;
			col_q       <= '0;
			phase_q     <= PH_LEAD;
			kbeg_q      <= '0;
			klast_q     <= '0;
			vbeg_q      <= '0;
			vlast_q     <= '0;
			vmark_q     <= '0;
			nidx_q      <= '0;
			nalive_q    <= 4'hF;
			cut_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				sect_q   <= n_sect;
				pos_q    <= n_pos;
				lbeg_q   <= n_lbeg;
				col_q    <= n_col;
				phase_q  <= n_phase;
				kbeg_q   <= n_kbeg;
				klast_q  <= n_klast;
				vbeg_q   <= n_vbeg;
				vlast_q  <= n_vlast;
				vmark_q  <= n_vmark;
				nidx_q   <= n_nidx;
				nalive_q <= n_nalive;
				cut_q    <= n_cut;
			end
			if (go && emit) begin
				out_valid_q <= 1'b1;
			end else if (desc_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire
